### hdl/ttuc_pkg.sv
// Shared types, codes and constants for the tick/time unit converter.
// Used by every module of the converter; depends on nothing else.
package ttuc_pkg;

  // Number of restoring divide cells in one divider chain.
  localparam int unsigned DivSteps = 64;
  // Number of partial-product cells (three for each of two products).
  localparam int unsigned MulSteps = 6;

  localparam logic [63:0] AllOnes64 = {64{1'b1}};
  localparam logic [31:0] AllOnes32 = {32{1'b1}};

  localparam logic [31:0] FreqNarrowReset = 32'd1000000;
  localparam logic [63:0] FreqWideReset   = 64'd1000000000;

  // Conversion codes carried in the kind field.
  typedef enum logic [2:0] {
    KIND_T32_FLOOR = 3'd0,
    KIND_T32_CEIL  = 3'd1,
    KIND_U32_CEIL  = 3'd2,
    KIND_T64_FLOOR = 3'd3,
    KIND_T64_CEIL  = 3'd4,
    KIND_U64_CEIL  = 3'd5
  } kind_e;

  // Configuration register indexes.
  typedef enum logic {
    REG_FREQ_NARROW = 1'b0,
    REG_FREQ_WIDE   = 1'b1
  } cfg_reg_e;

  // Which 32-bit halves a multiply cell combines.
  typedef enum logic [1:0] {
    PART_LL = 2'd0,
    PART_LH = 2'd1,
    PART_HL = 2'd2
  } part_e;

  // One item in flight through the cell chains.
  typedef struct packed {
    logic        vld;
    logic [2:0]  kind;
    logic        dz;    // divisor is zero
    logic [31:0] fac;
    logic [63:0] den;
    logic [63:0] num;   // dividend shifting out, quotient shifting in
    logic [63:0] rem;
    logic [63:0] acc;   // whole-second product, or the finished narrow result
    logic [63:0] aux;   // remainder product
  } ttuc_item_t;

  // True for the three 64-bit conversions.
  function automatic logic is_wide(input logic [2:0] kind);
    logic res;
    res = (kind == KIND_T64_FLOOR) || (kind == KIND_T64_CEIL) || (kind == KIND_U64_CEIL);
    return res;
  endfunction

  // Halves used by multiply step k.
  function automatic part_e step_part(input int unsigned k);
    part_e res;
    case (k % 3)
      0:       res = PART_LL;
      1:       res = PART_LH;
      default: res = PART_HL;
    endcase
    return res;
  endfunction

endpackage

### hdl/tick_time_unit_converter.sv
// Top level of the tick/time unit converter: register file, input stage,
// two divider cell chains with a multiply chain between them, output register.
// Depends on ttuc_pkg, ttuc_div_cell and ttuc_mul_cell.
//
//   Channel | Handshake               | Payload
//   --------+-------------------------+------------------------------------
//   in      | in_valid_i / in_stall_o | kind_i, value_i, factor_i
//   out     | out_valid_o/ out_stall_i| converted_o
//   cfg     | cfg_valid_i/ cfg_ready_o| cfg_index_i, cfg_data_i
//
// One item is taken per cycle while the input is not stalled. The item passes
// 137 registers: input stage, 64 divide cells, the middle register, 6 multiply
// cells, 64 divide cells and the output register.
// The whole chain advances together; it halts only
// while a result waits in the output register under stall, and the input is
// stalled in exactly those cycles. Reset empties the chain and loads the
// frequency registers with their default values. Config writes are always ready.
module tick_time_unit_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [63:0] value_i,
  input  logic [31:0] factor_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] converted_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  ttuc_pkg::cfg_reg_e cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import ttuc_pkg::*;

  logic [31:0] freq_narrow_q;
  logic [63:0] freq_wide_q;
  logic        adv;
  ttuc_item_t  in_d, in_q;
  ttuc_item_t  div1 [0:DivSteps];
  ttuc_item_t  mid_d, mid_q;
  ttuc_item_t  mul [0:MulSteps];
  ttuc_item_t  div2_in;
  ttuc_item_t  div2 [0:DivSteps];
  logic [63:0] narrow_res, wide_res, out_d, out_q;
  logic [2:0]  out_kind_q;
  logic        out_valid_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_narrow_q <= FreqNarrowReset;
      freq_wide_q   <= FreqWideReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_FREQ_NARROW: freq_narrow_q <= cfg_data_i[31:0];
        REG_FREQ_WIDE:   freq_wide_q   <= cfg_data_i;
        default:         freq_narrow_q <= freq_narrow_q;
      endcase
    end
  end

  // The chain moves unless a held result is stalled.
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // Input stage: narrow kinds form their 64-bit product, wide kinds divide value.
  always_comb begin
    in_d      = '0;
    in_d.vld  = in_valid_i;
    in_d.kind = kind_i;
    in_d.fac  = factor_i;
    case (kind_i)
      KIND_T32_FLOOR, KIND_T32_CEIL: begin
        in_d.num = 64'(value_i[31:0]) * 64'(factor_i);
        in_d.den = {32'b0, freq_narrow_q};
      end
      KIND_U32_CEIL: begin
        in_d.num = 64'(value_i[31:0]) * 64'(freq_narrow_q);
        in_d.den = {32'b0, factor_i};
      end
      KIND_T64_FLOOR, KIND_T64_CEIL: begin
        in_d.num = value_i;
        in_d.den = freq_wide_q;
      end
      default: begin
        in_d.num = value_i;
        in_d.den = {32'b0, factor_i};
      end
    endcase
    in_d.dz = (in_d.den == 64'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q <= '0;
    end else if (adv) begin
      in_q <= in_d;
    end
  end

  // First divider chain.
  assign div1[0] = in_q;

  for (genvar i = 0; i < DivSteps; i++) begin : g_div1
    ttuc_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .item_i (div1[i]),
      .item_o (div1[i+1])
    );
  end

  // Narrow kinds finish here; wide kinds keep seconds and remainder.
  always_comb begin
    mid_d      = div1[DivSteps];
    narrow_res = div1[DivSteps].num;
    if (div1[DivSteps].kind != KIND_T32_FLOOR && div1[DivSteps].rem != 64'b0) begin
      narrow_res = div1[DivSteps].num + 64'd1;
    end
    mid_d.acc = div1[DivSteps].dz ? {32'b0, AllOnes32} : {32'b0, narrow_res[31:0]};
    if (is_wide(div1[DivSteps].kind)) begin
      mid_d.acc = '0;
    end
    mid_d.aux = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= '0;
    end else if (adv) begin
      mid_q <= mid_d;
    end
  end

  // Multiply chain: seconds times scale, then remainder times scale.
  assign mul[0] = mid_q;

  for (genvar k = 0; k < MulSteps; k++) begin : g_mul
    ttuc_mul_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (adv),
      .part_i      (step_part(k)),
      .to_aux_i    (k >= (MulSteps / 2)),
      .freq_wide_i (freq_wide_q),
      .item_i      (mul[k]),
      .item_o      (mul[k+1])
    );
  end

  // Second divider chain divides the remainder product.
  always_comb begin
    div2_in     = mul[MulSteps];
    div2_in.num = mul[MulSteps].aux;
    div2_in.rem = '0;
  end

  assign div2[0] = div2_in;

  for (genvar i = 0; i < DivSteps; i++) begin : g_div2
    ttuc_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .item_i (div2[i]),
      .item_o (div2[i+1])
    );
  end

  // Final sum and the special cases.
  always_comb begin
    wide_res = div2[DivSteps].acc + div2[DivSteps].num;
    if (div2[DivSteps].kind != KIND_T64_FLOOR && div2[DivSteps].rem != 64'b0) begin
      wide_res = wide_res + 64'd1;
    end
    case (div2[DivSteps].kind)
      KIND_T32_FLOOR, KIND_T32_CEIL, KIND_U32_CEIL: out_d = div2[DivSteps].acc;
      KIND_T64_FLOOR, KIND_T64_CEIL, KIND_U64_CEIL: begin
        out_d = div2[DivSteps].dz ? AllOnes64 : wide_res;
      end
      default: out_d = '0;
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_kind_q  <= '0;
    end else if (adv) begin
      out_valid_q <= div2[DivSteps].vld;
      out_kind_q  <= div2[DivSteps].kind;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign converted_o = out_q;

  // A stalled result freezes the chain behind it.
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(div2[DivSteps]))
    else $error("chain moved while a result was stalled");

  // Narrow conversions never set the upper half.
  a_narrow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_kind_q == KIND_T32_FLOOR || out_kind_q == KIND_T32_CEIL ||
     out_kind_q == KIND_U32_CEIL)) |-> (converted_o[63:32] == 32'b0))
    else $error("narrow result has upper bits set");

  // Unused kinds give zero.
  a_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_kind_q > KIND_U64_CEIL) |-> (converted_o == 64'b0))
    else $error("unused kind gave a nonzero result");

endmodule

### hdl/ttuc_div_cell.sv
// One restoring division cell: retires one quotient bit per item.
// Depends on ttuc_pkg for the item type.
module ttuc_div_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  ttuc_pkg::ttuc_item_t item_i,
  output ttuc_pkg::ttuc_item_t item_o
);
  import ttuc_pkg::*;

  ttuc_item_t item_d, item_q;
  logic [64:0] trial;
  logic        fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  always_comb begin
    item_d = item_i;
    trial  = {item_i.rem, item_i.num[63]};
    fits   = trial >= {1'b0, item_i.den};
    item_d.rem = fits ? 64'(trial - {1'b0, item_i.den}) : trial[63:0];
    item_d.num = {item_i.num[62:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else if (en_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

### hdl/ttuc_mul_cell.sv
// One partial-product cell of the wrapping 64x64 multiply.
// Depends on ttuc_pkg for the item type and the part codes.
module ttuc_mul_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  ttuc_pkg::part_e     part_i,
  input  logic                to_aux_i,
  input  logic [63:0]         freq_wide_i,
  input  ttuc_pkg::ttuc_item_t item_i,
  output ttuc_pkg::ttuc_item_t item_o
);
  import ttuc_pkg::*;

  ttuc_item_t  item_d, item_q;
  logic [63:0] opa, opb, prod, term;
  logic [31:0] pa, pb;

  // Whole seconds go to acc, the remainder to aux; the scale is the factor
  // or, for unit to tick, the wide frequency.
  always_comb begin
    item_d = item_i;
    opa    = to_aux_i ? item_i.rem : item_i.num;
    opb    = (item_i.kind == KIND_U64_CEIL) ? freq_wide_i : {32'b0, item_i.fac};
    case (part_i)
      PART_LL: begin
        pa = opa[31:0];
        pb = opb[31:0];
      end
      PART_LH: begin
        pa = opa[31:0];
        pb = opb[63:32];
      end
      default: begin
        pa = opa[63:32];
        pb = opb[31:0];
      end
    endcase
    prod = 64'(pa) * 64'(pb);
    term = (part_i == PART_LL) ? prod : {prod[31:0], 32'b0};
    if (is_wide(item_i.kind)) begin
      if (to_aux_i) begin
        item_d.aux = item_i.aux + term;
      end else begin
        item_d.acc = item_i.acc + term;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else if (en_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule
